### hdl/twe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tape wave encoder package
// Field widths, operation codes and register indexes shared by the encoder.
// ----------------------------------------------------------------------------
package twe_pkg;

  localparam int unsigned OpW       = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 16;
  localparam int unsigned DurW      = 32;
  localparam int unsigned PulseW    = 13;
  localparam int unsigned PauseW    = 32;
  localparam int unsigned ChkW      = 16;
  localparam int unsigned StepW     = 5;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [PulseW-1:0] PulseTicksReset = 13'd100;
  localparam logic [PauseW-1:0] PauseTicksReset = 32'd10000;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 3'd0,
    OP_PAUSE  = 3'd1,
    OP_PILOT  = 3'd2,
    OP_HEADER = 3'd3,
    OP_DATA   = 3'd4,
    OP_WORD   = 3'd5
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PULSE_TICKS = 1'd0,
    CFG_PAUSE_TICKS = 1'd1
  } cfg_idx_e;

  // Pilot steps: the short-wave run, then sync, long and short.
  localparam logic [StepW-1:0] PilotRun   = 5'd0;
  localparam logic [StepW-1:0] PilotSync  = 5'd1;
  localparam logic [StepW-1:0] PilotLong  = 5'd2;
  localparam logic [StepW-1:0] PilotShort = 5'd3;

endpackage

`default_nettype wire

### hdl/twe_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tape wave encoder channels
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface twe_in_if;
  import twe_pkg::*;
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    op;
  logic [ByteW-1:0]  value;
  logic [CountW-1:0] pilot_count;
  modport source (output valid, op, value, pilot_count, input ready);
  modport sink   (input valid, op, value, pilot_count, output ready);
endinterface

interface twe_out_if;
  import twe_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_pause;
  logic [DurW-1:0]   duration;
  logic [CountW-1:0] repeat_res;
  logic              last;
  modport source (output valid, is_pause, duration, repeat_res, last, input ready);
  modport sink   (input valid, is_pause, duration, repeat_res, last, output ready);
endinterface

interface twe_cfg_if;
  import twe_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/tape_wave_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tape wave encoder
// Turns tape-record commands into pulse-width wave runs and pauses.
// ----------------------------------------------------------------------------
// One result word leaves per clock while the sink is ready. A command is held
// in a command register and stepped through its waves; each step is decoded
// into the result register. A pause yields 1 word, a pilot 3 or 4, a header
// or data byte 16 words and a checksum word 32, so the result port sets the rate.
// The next command is taken in the cycle its final word enters the result
// register. Checksum clears and unused codes produce no words and are simply
// absorbed. The configuration port is always ready.
module tape_wave_encoder
  import twe_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  twe_cfg_if.sink   cfg_i,
  twe_in_if.sink    in_i,
  twe_out_if.source res_o
);

  logic [PulseW-1:0] pulse_ticks_q;
  logic [PauseW-1:0] pause_ticks_q;
  logic [ChkW-1:0]   checksum_q, checksum_d;

  logic              busy_q, busy_d;
  op_e               op_q, op_d;
  logic [ChkW-1:0]   data_q, data_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [StepW-1:0]  step_q, step_d;

  logic              out_valid_q, out_valid_d;
  logic              res_pause_q, res_pause_d;
  logic [DurW-1:0]   res_dur_q, res_dur_d;
  logic [CountW-1:0] res_rep_q, res_rep_d;
  logic              res_last_q;

  logic              adv;
  logic              cur_last;
  logic              in_acc;
  logic [ChkW:0]     chk_sum;
  logic [DurW-1:0]   short_dur, long_dur, sync_dur;
  logic              bit_val;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_ticks_q <= PulseTicksReset;
      pause_ticks_q <= PauseTicksReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_PULSE_TICKS: pulse_ticks_q <= cfg_i.data[PulseW-1:0];
        CFG_PAUSE_TICKS: pause_ticks_q <= cfg_i.data[PauseW-1:0];
        default: ;
      endcase
    end
  end

  assign short_dur = DurW'({pulse_ticks_q, 1'b0});
  assign long_dur  = DurW'({pulse_ticks_q, 2'b0});
  assign sync_dur  = DurW'({pulse_ticks_q, 3'b0});
  assign bit_val   = data_q[step_q[StepW-1:1]];

  // Decode the current step into one result word.
  always_comb begin
    res_pause_d = 1'b0;
    res_dur_d   = short_dur;
    res_rep_d   = CountW'(1);
    cur_last    = 1'b0;
    unique case (op_q)
      OP_PAUSE: begin
        res_pause_d = 1'b1;
        res_dur_d   = pause_ticks_q;
        cur_last    = 1'b1;
      end
      OP_PILOT: begin
        unique case (step_q)
          PilotRun:  res_rep_d = cnt_q;
          PilotSync: res_dur_d = sync_dur;
          PilotLong: res_dur_d = long_dur;
          default:   cur_last  = 1'b1;
        endcase
      end
      OP_HEADER, OP_DATA, OP_WORD: begin
        // Even steps carry the bit, odd steps the trailing short wave.
        if (!step_q[0] && bit_val) begin
          res_dur_d = long_dur;
        end
        cur_last = (step_q == {op_q == OP_WORD, 4'hF});
      end
      default: cur_last = 1'b1;
    endcase
  end

  assign adv         = !out_valid_q || res_o.ready;
  assign in_i.ready  = !busy_q || (adv && cur_last);
  assign in_acc      = in_i.valid && in_i.ready;
  assign chk_sum     = {1'b0, checksum_q} + (ChkW+1)'(in_i.value);

  always_comb begin
    busy_d      = busy_q;
    op_d        = op_q;
    data_d      = data_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    checksum_d  = checksum_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        step_d = step_q + StepW'(1);
        if (cur_last) begin
          busy_d = 1'b0;
        end
      end
    end
    if (in_acc) begin
      op_d   = op_e'(in_i.op);
      cnt_d  = in_i.pilot_count;
      data_d = {{(ChkW-ByteW){1'b0}}, in_i.value};
      step_d = '0;
      unique case (op_e'(in_i.op))
        OP_CLEAR: checksum_d = '0;
        OP_PAUSE, OP_HEADER: busy_d = 1'b1;
        OP_PILOT: begin
          busy_d = 1'b1;
          if (in_i.pilot_count == '0) begin
            step_d = PilotSync;
          end
        end
        OP_DATA: begin
          busy_d     = 1'b1;
          // End-around carry: a carry out of the word is added back in.
          checksum_d = chk_sum[ChkW-1:0] + ChkW'(chk_sum[ChkW]);
        end
        OP_WORD: begin
          busy_d = 1'b1;
          data_d = checksum_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      checksum_q  <= '0;
      step_q      <= '0;
      op_q        <= OP_CLEAR;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      checksum_q  <= checksum_d;
      step_q      <= step_d;
      op_q        <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    cnt_q  <= cnt_d;
    if (adv) begin
      res_pause_q <= res_pause_d;
      res_dur_q   <= res_dur_d;
      res_rep_q   <= res_rep_d;
      res_last_q  <= cur_last;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.is_pause   = res_pause_q;
  assign res_o.duration   = res_dur_q;
  assign res_o.repeat_res = res_rep_q;
  assign res_o.last       = res_last_q;

`ifndef SYNTH
  // A new word is taken during a command only as its final result moves out.
  a_accept_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && in_i.ready |-> adv && cur_last)
    else $error("command taken before the current one finished");

  // A command stays in work until its final result is issued.
  a_busy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !(adv && cur_last) && !in_acc |=> busy_q)
    else $error("command dropped before its final result");

  // A pause has a single step.
  a_pause_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && op_q == OP_PAUSE |-> step_q == '0)
    else $error("pause stepped past its only result");

  // An empty pilot run is never issued.
  a_pilot_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && op_q == OP_PILOT && cnt_q == '0 |-> step_q != PilotRun)
    else $error("pilot issued a zero-length run");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape wave encoder testbench
// Drives tape-record commands and register writes into the encoder and checks
// every result word against a cycle-free model of the wave encoding. A short
// table of directed commands comes first, then randomized tape records under
// several pulse and pause settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import twe_pkg::*;

  localparam int unsigned RunLimit     = 1_000_000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxWait      = 12;
  localparam int unsigned LongBlock    = 270;

  // Codes the encoder does not define; it must swallow them silently.
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  typedef struct packed {
    logic              is_pause;
    logic [DurW-1:0]   duration;
    logic [CountW-1:0] repeat_res;
    logic              last;
  } wave_t;

  typedef struct packed {
    logic                is_reg;
    cfg_idx_e            reg_idx;
    logic [CfgDataW-1:0] reg_data;
    logic [OpW-1:0]      op;
    logic [ByteW-1:0]    value;
    logic [CountW-1:0]   count;
    logic                typed;
    wave_t               first;
  } step_t;

  localparam wave_t NoWave = '0;

  logic clk_i;
  logic rst_ni;

  twe_cfg_if cfg_ch ();
  twe_in_if  cmd_ch ();
  twe_out_if wave_ch ();

  tape_wave_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (cmd_ch),
    .res_o  (wave_ch)
  );

  // Model state of the encoder.
  logic [PulseW-1:0] pulse_reg;
  logic [PauseW-1:0] pause_reg;
  logic [ChkW-1:0]   chk_word;

  wave_t       pending_waves[$];
  int unsigned mismatches = 0;
  int unsigned waves_seen = 0;
  int unsigned cycles     = 0;
  int unsigned sent       = 0;
  int unsigned sink_hold  = 0;
  bit          cmd_calm   = 1'b0;
  bit          wave_calm  = 1'b0;

  // Expected result of a row is typed in only where it is obvious at a glance.
  step_t plan [0:23] = '{
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_PAUSE, 8'h00, 16'd0, 1'b1,
      '{1'b1, 32'd10000, 16'd1, 1'b1}},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_PILOT, 8'h00, 16'd0, 1'b1,
      '{1'b0, 32'd800, 16'd1, 1'b0}},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_PILOT, 8'h00, 16'd1, 1'b1,
      '{1'b0, 32'd200, 16'd1, 1'b0}},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_HEADER, 8'h00, 16'd0, 1'b1,
      '{1'b0, 32'd200, 16'd1, 1'b0}},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_HEADER, 8'hff, 16'hffff, 1'b1,
      '{1'b0, 32'd400, 16'd1, 1'b0}},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_DATA, 8'hff, 16'd0, 1'b0, NoWave},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_DATA, 8'ha5, 16'd0, 1'b0, NoWave},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_WORD, 8'h00, 16'd0, 1'b0, NoWave},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OpSpare6, 8'hff, 16'hffff, 1'b0, NoWave},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OpSpare7, 8'h00, 16'd0, 1'b0, NoWave},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_CLEAR, 8'h00, 16'd0, 1'b0, NoWave},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_WORD, 8'h00, 16'd0, 1'b1,
      '{1'b0, 32'd200, 16'd1, 1'b0}},
    '{1'b1, CFG_PULSE_TICKS, 32'd8191, OP_CLEAR, 8'h00, 16'd0, 1'b0, NoWave},
    '{1'b1, CFG_PAUSE_TICKS, 32'hffff_ffff, OP_CLEAR, 8'h00, 16'd0, 1'b0, NoWave},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_PAUSE, 8'h00, 16'd0, 1'b1,
      '{1'b1, 32'hffff_ffff, 16'd1, 1'b1}},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_PILOT, 8'h00, 16'hffff, 1'b1,
      '{1'b0, 32'd16382, 16'hffff, 1'b0}},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_DATA, 8'h80, 16'd0, 1'b0, NoWave},
    '{1'b1, CFG_PULSE_TICKS, 32'd1, OP_CLEAR, 8'h00, 16'd0, 1'b0, NoWave},
    '{1'b1, CFG_PAUSE_TICKS, 32'd0, OP_CLEAR, 8'h00, 16'd0, 1'b0, NoWave},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_PAUSE, 8'h00, 16'd0, 1'b1,
      '{1'b1, 32'd0, 16'd1, 1'b1}},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_HEADER, 8'h01, 16'd0, 1'b1,
      '{1'b0, 32'd4, 16'd1, 1'b0}},
    '{1'b1, CFG_PULSE_TICKS, 32'd0, OP_CLEAR, 8'h00, 16'd0, 1'b0, NoWave},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_DATA, 8'h5a, 16'd0, 1'b1,
      '{1'b0, 32'd0, 16'd1, 1'b0}},
    '{1'b0, CFG_PULSE_TICKS, 32'd0, OP_WORD, 8'h00, 16'd0, 1'b0, NoWave}
  };

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MaxWait);
  endfunction

  function automatic logic [CountW-1:0] draw_pilot();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CountW'($urandom);
      default: return CountW'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [DurW-1:0] wave_ticks(int unsigned units);
    return DurW'(pulse_reg) * DurW'(units);
  endfunction

  function automatic void push_wave(logic pause, logic [DurW-1:0] dur,
                                    logic [CountW-1:0] rep);
    wave_t w;
    w = '{pause, dur, rep, 1'b0};
    pending_waves.push_back(w);
  endfunction

  // Each bit goes out LSB first as two waves: long+short or short+short.
  function automatic void push_byte(logic [ByteW-1:0] b);
    for (int i = 0; i < ByteW; i++) begin
      push_wave(1'b0, b[i] ? wave_ticks(4) : wave_ticks(2), 16'd1);
      push_wave(1'b0, wave_ticks(2), 16'd1);
    end
  endfunction

  function automatic void encode_command(logic [OpW-1:0] op, logic [ByteW-1:0] val,
                                         logic [CountW-1:0] cnt);
    int unsigned mark;
    logic [ChkW:0] sum;
    mark = pending_waves.size();
    case (op)
      OP_CLEAR: chk_word = '0;
      OP_PAUSE: push_wave(1'b1, pause_reg, 16'd1);
      OP_PILOT: begin
        if (cnt != 0) push_wave(1'b0, wave_ticks(2), cnt);
        push_wave(1'b0, wave_ticks(8), 16'd1);
        push_wave(1'b0, wave_ticks(4), 16'd1);
        push_wave(1'b0, wave_ticks(2), 16'd1);
      end
      OP_HEADER: push_byte(val);
      OP_DATA: begin
        push_byte(val);
        // End-around carry: a carry out of the word is added back in.
        sum = {1'b0, chk_word} + {{(ChkW + 1 - ByteW){1'b0}}, val};
        chk_word = sum[ChkW-1:0] + {{(ChkW - 1){1'b0}}, sum[ChkW]};
      end
      OP_WORD: begin
        push_byte(chk_word[7:0]);
        push_byte(chk_word[15:8]);
      end
      default: ;
    endcase
    if (pending_waves.size() > mark)
      pending_waves[pending_waves.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [DurW-1:0] got,
                                 logic [DurW-1:0] want);
    $display("mismatch in %s at word %0d: got %0h, want %0h",
             what, waves_seen, got, want);
    mismatches++;
  endtask

  task automatic send_cmd(logic [OpW-1:0] op, logic [ByteW-1:0] val,
                          logic [CountW-1:0] cnt, bit typed = 1'b0,
                          wave_t first = NoWave);
    int unsigned gap;
    int unsigned mark;
    gap = draw_wait(cmd_calm);
    // The valid stays up across back-to-back words and only drops for a gap.
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.op          <= op;
    cmd_ch.value       <= val;
    cmd_ch.pilot_count <= cnt;
    do @(posedge clk_i); while (!cmd_ch.ready);
    mark = pending_waves.size();
    encode_command(op, val, cnt);
    if (typed && pending_waves.size() > mark) pending_waves[mark] = first;
    if (op <= OP_WORD) sent++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data, bit more);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (!more) cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_PULSE_TICKS: pulse_reg = data[PulseW-1:0];
      CFG_PAUSE_TICKS: pause_reg = data[PauseW-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (pending_waves.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One tape record: pause, pilot, header, pilot, data block, checksum word,
  // sometimes broken up or preceded by stray commands.
  task automatic send_record(bit long_block);
    int unsigned n;
    cmd_calm  = ($urandom_range(0, 3) == 0);
    wave_calm = ($urandom_range(0, 3) == 0);
    if (!long_block && $urandom_range(0, 3) != 0)
      send_cmd(OP_CLEAR, ByteW'($urandom), CountW'($urandom));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        send_cmd(OpW'($urandom_range(0, 7)), ByteW'($urandom), CountW'($urandom));
    send_cmd(OP_PAUSE, ByteW'($urandom), CountW'($urandom));
    send_cmd(OP_PILOT, ByteW'($urandom), draw_pilot());
    if ($urandom_range(0, 7) != 0)
      repeat ($urandom_range(1, 18))
        send_cmd(OP_HEADER, ByteW'($urandom), CountW'($urandom));
    send_cmd(OP_PILOT, ByteW'($urandom), draw_pilot());
    n = long_block ? LongBlock : $urandom_range(1, 24);
    // A long run of high bytes pushes the checksum through its carry.
    repeat (n)
      send_cmd(OP_DATA, long_block ? ByteW'($urandom_range(8'hf4, 8'hff))
                                   : ByteW'($urandom), CountW'($urandom));
    if ($urandom_range(0, 7) != 0)
      send_cmd(OP_WORD, ByteW'($urandom), CountW'($urandom));
  endtask

  always @(posedge clk_i) begin
    if (wave_ch.valid && wave_ch.ready) begin
      sink_hold = draw_wait(wave_calm);
    end else if (sink_hold != 0) begin
      sink_hold--;
    end
    wave_ch.ready <= (sink_hold == 0);
  end

  always @(posedge clk_i) begin : wave_check
    wave_t want;
    if (rst_ni && wave_ch.valid && wave_ch.ready) begin
      waves_seen++;
      if (pending_waves.size() == 0) begin
        report_mismatch("unexpected word", wave_ch.duration, '0);
      end else begin
        want = pending_waves.pop_front();
        if (wave_ch.is_pause !== want.is_pause)
          report_mismatch("is_pause", DurW'(wave_ch.is_pause), DurW'(want.is_pause));
        if (wave_ch.duration !== want.duration)
          report_mismatch("duration", wave_ch.duration, want.duration);
        if (wave_ch.repeat_res !== want.repeat_res)
          report_mismatch("repeat_res", DurW'(wave_ch.repeat_res),
                          DurW'(want.repeat_res));
        if (wave_ch.last !== want.last)
          report_mismatch("last", DurW'(wave_ch.last), DurW'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == RunLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [CfgDataW-1:0] pulse_data;
    logic [CfgDataW-1:0] pause_data;
    int unsigned goal;
    pulse_reg = PulseTicksReset;
    pause_reg = PauseTicksReset;
    chk_word  = '0;
    rst_ni              = 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_PULSE_TICKS;
    cfg_ch.data        <= '0;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.op          <= OP_CLEAR;
    cmd_ch.value       <= '0;
    cmd_ch.pilot_count <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(plan); i++) begin
      if (plan[i].is_reg) begin
        if (i == 0 || !plan[i-1].is_reg) settle();
        write_reg(plan[i].reg_idx, plan[i].reg_data,
                  (i + 1 < $size(plan)) && plan[i+1].is_reg);
      end else begin
        send_cmd(plan[i].op, plan[i].value, plan[i].count, plan[i].typed,
                 plan[i].first);
      end
    end

    sent = 0;
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        1: begin
          pulse_data = 32'd1;
          pause_data = 32'd0;
        end
        2: begin
          pulse_data = 32'd8191;
          pause_data = 32'hffff_ffff;
        end
        default: begin
          // Bits above the pulse field are junk and must be dropped.
          pulse_data = ($urandom & 32'hffff_e000) | $urandom_range(1, 8191);
          pause_data = $urandom;
        end
      endcase
      write_reg(CFG_PULSE_TICKS, pulse_data, 1'b1);
      write_reg(CFG_PAUSE_TICKS, pause_data, 1'b0);
      if (p == 3) send_record(1'b1);
      goal = (p == 3) ? 430 : (p + 1) * 45;
      while (sent < goal) send_record(1'b0);
    end

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### tape_wave_encoder.f
hdl/twe_pkg.sv
hdl/twe_if.sv
hdl/tape_wave_encoder.sv
sim/tb.sv
